// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL datapath. The checks sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BRF_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define BRF_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BRF_ASSERT(name, expr, msg)

`define BRF_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// File: rtl/core/brfd_pkg.sv
`timescale 1ns / 1ps

package brfd_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        MODE_WRITE      = 2'd0,
        MODE_READ_LEN   = 2'd1,
        MODE_READ_DELIM = 2'd2,
        MODE_CLEAR      = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NO_DATA  = 2'd2;

    localparam logic [1:0] SEP_KEEP = 2'd0;
    localparam logic [1:0] SEP_ZERO = 2'd1;
    localparam logic [1:0] SEP_EMIT = 2'd2;

    typedef struct packed {
        mode_t            mode;
        logic [7:0]       data_in;
        logic             write_first;
        logic [CNT_W-1:0] length;
        logic             pop_req;
        logic             emit_data;
        logic [7:0]       delimiter;
        logic [1:0]       sep_mode;
    } req_item_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             data_valid;
        logic             last;
        logic [1:0]       status;
        logic [CNT_W-1:0] used_count;
        logic [CNT_W-1:0] free_count_out;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic scan_finish;
        logic emit;
        logic hold;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic scan_done;
        logic emit_last;
    } dp_status_t;

    // Advance a ring index by one, wrapping at the configured capacity.
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
    endfunction

    // Advance a ring index by amt (amt never exceeds cap).
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] amt,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(idx) + (CNT_W+1)'(amt);
        if (sum >= (CNT_W+1)'(cap))
        begin
            sum = sum - (CNT_W+1)'(cap);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/byte_ring_fifo_delimited_read_core.sv
`timescale 1ns / 1ps
// Write and clear items can be accepted every cycle while the result register is free; the
// result is registered and shows in the cycle after acceptance.
// A length read is accepted, then emits its results in order (one result if no byte).
// A delimiter read scans one stored byte per cycle through the single memory read port,
// then emits one result per cycle while the output is not stalled.
// Reset (rst_n, asynchronous) empties the ring and sets capacity to 64; bytes are not cleared.

module byte_ring_fifo_delimited_read_core
    import brfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_item_t        req_item,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp_item
);

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    brfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_item.mode),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    brfd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

// File: rtl/core/brfd_ctrl.sv
`timescale 1ns / 1ps

module brfd_ctrl
    import brfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  mode_t      req_mode,
    output logic       req_stall,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       take_item;

    assign take_item = (state_reg == ST_IDLE) && st.slot_free && req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_item && req_mode == MODE_READ_LEN)
                begin
                    state_next = ST_EMIT;
                end
                else if (take_item && req_mode == MODE_READ_DELIM)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (st.slot_free && st.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                // Writes and clears load the result register at acceptance.
                req_stall  = !st.slot_free;
                cmd.accept = take_item;
            end
            ST_SCAN:
            begin
                cmd.scan_step   = !st.scan_done;
                cmd.scan_finish = st.scan_done;
            end
            ST_EMIT:
            begin
                cmd.emit = st.slot_free;
                cmd.hold = !st.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/brfd_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brfd_datapath
    import brfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  req_item_t        req_item,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       st,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp_item
);

    logic [7:0] store_mem [DEPTH];

    logic [CNT_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rejected_reg, rejected_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0] emit_n_reg, emit_n_next;
    logic [CNT_W-1:0] emit_k_reg, emit_k_next;
    logic             pop_reg, pop_next;
    logic [7:0]       delim_reg, delim_next;
    logic [1:0]       sep_reg, sep_next;
    logic [1:0]       status_reg, status_next;
    logic             zero_sub_reg, zero_sub_next;
    logic [7:0]       rdata_reg;
    logic             out_valid_reg, out_valid_next;
    rsp_item_t        out_item_reg, out_item_next;

    logic [CNT_W-1:0] used_now;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] take;
    logic             len_over;
    logic             scan_end;
    logic             scan_hit;
    logic             sep_add;
    logic [CNT_W-1:0] hit_n;
    logic             emit_last;
    logic             slot_free;
    logic             store_en;
    logic             out_load;
    logic [7:0]       o_data;
    logic             o_dv;
    logic             o_last;
    logic [1:0]       o_status;
    logic             is_read;
    logic [CNT_W-1:0] cfg_cap;
    logic [CNT_W-1:0] rd_idx_ext;
    logic [CNT_W-1:0] wr_idx_ext;

    assign used_now   = capacity_reg - free_count_reg;
    assign need       = (req_item.length == '0) ? CNT_W'(1) : req_item.length;
    assign len_over   = req_item.length > used_now;
    assign take       = len_over ? used_now : req_item.length;
    assign scan_end   = scan_cnt_reg == used_now;
    assign scan_hit   = !scan_end && (rdata_reg == delim_reg);
    assign sep_add    = (sep_reg == SEP_ZERO) || (sep_reg == SEP_EMIT);
    assign hit_n      = scan_cnt_reg + CNT_W'(sep_add);
    assign emit_last  = (emit_n_reg == '0) || (emit_k_reg == emit_n_reg - CNT_W'(1));
    assign slot_free  = !out_valid_reg || !rsp_stall;
    assign is_read    = (req_item.mode == MODE_READ_LEN) || (req_item.mode == MODE_READ_DELIM);
    assign rd_idx_ext = CNT_W'(rd_idx_reg);
    assign wr_idx_ext = CNT_W'(wr_idx_reg);

    assign st.slot_free = slot_free;
    assign st.scan_done = scan_end || scan_hit;
    assign st.emit_last = emit_last;

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_cap = CNT_W'(1);
        end
        else if (cfg_data > CAP_RESET)
        begin
            cfg_cap = CAP_RESET;
        end
        else
        begin
            cfg_cap = cfg_data;
        end
    end

    always_comb
    begin
        capacity_next   = capacity_reg;
        free_count_next = free_count_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        rejected_next   = rejected_reg;
        remain_next     = remain_reg;
        scan_cnt_next   = scan_cnt_reg;
        emit_n_next     = emit_n_reg;
        emit_k_next     = emit_k_reg;
        pop_next        = pop_reg;
        delim_next      = delim_reg;
        sep_next        = sep_reg;
        status_next     = status_reg;
        zero_sub_next   = zero_sub_reg;
        store_en        = 1'b0;
        out_load        = 1'b0;
        o_data          = '0;
        o_dv            = 1'b0;
        o_last          = 1'b1;
        o_status        = STATUS_OK;

        if (cfg_we)
        begin
            capacity_next   = cfg_cap;
            free_count_next = cfg_cap;
            wr_idx_next     = '0;
            rd_idx_next     = '0;
            rejected_next   = 1'b0;
            remain_next     = '0;
        end
        else if (cmd.accept)
        begin
            case (req_item.mode)
                MODE_WRITE:
                begin
                    // The space check for a whole message is made on its first byte.
                    if (req_item.write_first)
                    begin
                        remain_next = need - CNT_W'(1);
                        if (need > free_count_reg)
                        begin
                            rejected_next = 1'b1;
                            o_status      = STATUS_NO_SPACE;
                        end
                        else
                        begin
                            rejected_next = 1'b0;
                            store_en      = 1'b1;
                        end
                    end
                    else if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - CNT_W'(1);
                        if (rejected_reg)
                        begin
                            o_status = STATUS_NO_SPACE;
                        end
                        else if (free_count_reg == '0)
                        begin
                            rejected_next = 1'b1;
                            o_status      = STATUS_NO_SPACE;
                        end
                        else
                        begin
                            store_en = 1'b1;
                        end
                    end
                    if (store_en)
                    begin
                        wr_idx_next     = wrap_inc(wr_idx_reg, capacity_reg);
                        free_count_next = free_count_reg - CNT_W'(1);
                    end
                    out_load = 1'b1;
                end
                MODE_CLEAR:
                begin
                    free_count_next = capacity_reg;
                    wr_idx_next     = '0;
                    rd_idx_next     = '0;
                    rejected_next   = 1'b0;
                    remain_next     = '0;
                    out_load        = 1'b1;
                end
                MODE_READ_LEN:
                begin
                    status_next   = len_over ? STATUS_NO_DATA : STATUS_OK;
                    emit_n_next   = req_item.emit_data ? take : '0;
                    emit_k_next   = '0;
                    zero_sub_next = 1'b0;
                    if (req_item.pop_req)
                    begin
                        free_count_next = free_count_reg + take;
                        rd_idx_next     = wrap_add(rd_idx_reg, take, capacity_reg);
                    end
                end
                MODE_READ_DELIM:
                begin
                    pop_next      = req_item.pop_req;
                    delim_next    = req_item.delimiter;
                    sep_next      = req_item.sep_mode;
                    scan_cnt_next = '0;
                    emit_k_next   = '0;
                end
                default:
                begin
                    out_load = 1'b0;
                end
            endcase
        end
        else if (cmd.scan_step)
        begin
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end
        else if (cmd.scan_finish)
        begin
            emit_k_next = '0;
            if (scan_end)
            begin
                // No separator: everything stored is shown and nothing is popped.
                emit_n_next   = used_now;
                status_next   = STATUS_NO_DATA;
                zero_sub_next = 1'b0;
            end
            else
            begin
                emit_n_next   = hit_n;
                status_next   = STATUS_OK;
                zero_sub_next = sep_reg == SEP_ZERO;
                if (pop_reg)
                begin
                    free_count_next = free_count_reg + hit_n;
                    rd_idx_next     = wrap_add(rd_idx_reg, hit_n, capacity_reg);
                end
            end
        end
        else if (cmd.emit)
        begin
            out_load = 1'b1;
            o_dv     = emit_n_reg != '0;
            o_last   = emit_last;
            o_status = status_reg;
            o_data   = (o_dv && !(emit_last && zero_sub_reg)) ? rdata_reg : '0;
            if (!emit_last)
            begin
                emit_k_next = emit_k_reg + CNT_W'(1);
            end
        end

        out_item_next.data_out       = o_data;
        out_item_next.data_valid     = o_dv;
        out_item_next.last           = o_last;
        out_item_next.status         = o_status;
        out_item_next.used_count     = capacity_next - free_count_next;
        out_item_next.free_count_out = free_count_next;
    end

    // The memory is always read at the next pointer, so rdata_reg holds the
    // byte at cur_reg.
    always_comb
    begin
        if (cmd.scan_step || (cmd.emit && !emit_last))
        begin
            cur_next = wrap_inc(cur_reg, capacity_reg);
        end
        else if (cmd.scan_finish)
        begin
            cur_next = rd_idx_reg;
        end
        else if (cmd.hold || (cmd.accept && is_read))
        begin
            cur_next = cur_reg;
        end
        else
        begin
            cur_next = rd_idx_next;
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            free_count_reg <= CAP_RESET;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            rejected_reg   <= 1'b0;
            remain_reg     <= '0;
            cur_reg        <= '0;
            scan_cnt_reg   <= '0;
            emit_n_reg     <= '0;
            emit_k_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            capacity_reg   <= capacity_next;
            free_count_reg <= free_count_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            rejected_reg   <= rejected_next;
            remain_reg     <= remain_next;
            cur_reg        <= cur_next;
            scan_cnt_reg   <= scan_cnt_next;
            emit_n_reg     <= emit_n_next;
            emit_k_reg     <= emit_k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_reg      <= pop_next;
        delim_reg    <= delim_next;
        sep_reg      <= sep_next;
        status_reg   <= status_next;
        zero_sub_reg <= zero_sub_next;
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[wr_idx_reg] <= req_item.data_in;
        end
        rdata_reg <= store_mem[cur_next];
    end

    `BRF_ASSERT(a_cap_range, capacity_reg != '0 && capacity_reg <= CAP_RESET, "capacity out of range")
    `BRF_ASSERT(a_free_le_cap, free_count_reg <= capacity_reg, "free count exceeds capacity")
    `BRF_ASSERT(a_idx_range, rd_idx_ext < capacity_reg && wr_idx_ext < capacity_reg, "ring index out of range")
    `BRF_ASSERT(a_emit_cnt, (emit_n_reg == '0) ? (emit_k_reg == '0) : (emit_k_reg < emit_n_reg), "emit counter past end")
    `BRF_ASSERT(a_no_overwrite, !out_load || slot_free, "result register overwritten before transfer")
    `BRF_ASSERT_NEXT(a_scan_restart, cmd.scan_finish, cur_reg == rd_idx_ext[IDX_W-1:0] || pop_reg, "emit pointer not restarted")

endmodule
